[hdl/cbm_pkg.sv]
// Shared types, address decode constants and helpers for the cartridge bank mapper.
// No dependencies; used by the top level and by its port checker.
`default_nettype none

package cbm_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // Input tdata layout: address, data, cycles from the lowest bit up
  localparam int unsigned IN_TDATA_W  = 32;
  // Output tdata layout: five banks, chr bank, mirroring, irq line, zero fill
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [15:0] LATCH_LO   = 16'h8000;
  localparam logic [15:0] LATCH_HI   = 16'hA000;  // exclusive
  localparam logic [15:0] REG_LO     = 16'h4020;
  localparam logic [15:0] REG_HI     = 16'h5FFF;  // inclusive
  localparam int unsigned A_SEL_BIT  = 5;         // must be set
  localparam int unsigned A_MASK_BIT = 6;         // must be clear
  localparam int unsigned A_IRQ_BIT  = 8;         // set: irq enable, clear: bank register
  localparam int unsigned IRQ_BIT    = 12;        // counter bit driving the line

  localparam logic [7:0] BANK_6000   = 8'h07;
  localparam logic [7:0] FIXED_BANK0 = 8'h00;
  localparam logic [7:0] FIXED_BANK1 = 8'h01;
  localparam logic [7:0] FIXED_BANK3 = 8'h03;

  // Program layout modes picked by latch bits 7..6
  localparam logic [1:0] MODE_8K  = 2'b00;
  localparam logic [1:0] MODE_16K = 2'b01;

  typedef struct packed {
    logic [7:0]  latch;
    logic [7:0]  scr_bank;
    logic        irq_en;
    logic [15:0] irq_cnt;
    logic        irq_line;
  } state_t;

  typedef struct packed {
    logic       irq_line;
    logic       mirroring;
    logic [1:0] chr_bank;
    logic [7:0] bank_e000;
    logic [7:0] bank_c000;
    logic [7:0] bank_a000;
    logic [7:0] bank_8000;
    logic [7:0] bank_6000;
  } result_t;

  function automatic logic [7:0] scramble(input logic [7:0] d);
    scramble = {d[7:3], d[0], d[2:1]};
  endfunction

endpackage

`default_nettype wire

[hdl/cartridge_bank_mapper_with_irq.sv]
// Cartridge bank mapper: bus write decode, bank layout and cycle-counting IRQ.
// Depends on cbm_pkg for constants, the state and result structs and the scramble helper.
//
// Usage:
//   Input channel (in_*): one request per bus write (in_tuser = 0) or cycle tick
//   (in_tuser = 1). in_tdata carries address, data and cycle count.
//   Output channel (out_*): one result per request, showing the mapping after
//   that request: five 8K program banks, chr bank, mirroring and the IRQ line.
//   Latency: a result appears on out_* the cycle after its request is taken.
//   Throughput: one request per cycle unless stalled; the decode, layout select
//   and 16-bit counter add all sit between the input port and the result register.
//   in_tready stays high while the result register is empty or being drained,
//   so a new request is taken in the same cycle the previous result leaves.
//   Stall: while out_tvalid is high and out_tready low, the result holds and
//   in_tready drops; no request is taken until the result is delivered.
//   Reset (rst_n low, synchronous): latch, bank register, IRQ enable, counter
//   and IRQ line clear, and the result register empties.
`default_nettype none

module cartridge_bank_mapper_with_irq (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [15:0] address, [23:16] data, [31:24] cycles
  input  wire logic [cbm_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] operation
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [7:0] bank_6000, [15:8] bank_8000, [23:16] bank_a000, [31:24] bank_c000,
  // [39:32] bank_e000, [41:40] chr_bank, [42] mirroring, [43] irq_line, rest zero
  output logic [cbm_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  cbm_pkg::state_t  st_r, st_nxt;
  cbm_pkg::result_t res_r, res_nxt;
  logic             vld_r, vld_nxt;

  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [7:0]  cycles;
  logic        accept;
  logic        hit_latch;
  logic        hit_reg;
  logic [15:0] cnt_sum;
  logic [2:0]  pg;
  logic [7:0]  b8, ba, bc, be;

  assign addr   = in_tdata[15:0];
  assign wdata  = in_tdata[23:16];
  assign cycles = in_tdata[31:24];

  assign in_tready = !vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign hit_latch = (addr >= cbm_pkg::LATCH_LO) && (addr < cbm_pkg::LATCH_HI);
  assign hit_reg   = (addr >= cbm_pkg::REG_LO) && (addr <= cbm_pkg::REG_HI)
                     && addr[cbm_pkg::A_SEL_BIT] && !addr[cbm_pkg::A_MASK_BIT];
  assign cnt_sum   = st_r.irq_cnt + {8'd0, cycles};

  // Next state for the request on the input port
  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      if (cbm_pkg::op_t'(in_tuser) == cbm_pkg::OP_WRITE) begin
        if (hit_latch) begin
          st_nxt.latch = wdata;
        end else if (hit_reg) begin
          if (addr[cbm_pkg::A_IRQ_BIT]) begin
            st_nxt.irq_en = wdata[0];
            if (!wdata[0]) begin
              st_nxt.irq_cnt  = '0;
              st_nxt.irq_line = 1'b0;
            end
          end else begin
            st_nxt.scr_bank = cbm_pkg::scramble(wdata);
          end
        end
      end else if (st_r.irq_en) begin
        st_nxt.irq_cnt  = cnt_sum;
        st_nxt.irq_line = cnt_sum[cbm_pkg::IRQ_BIT];
      end
    end
  end

  // Program layout from the updated latch
  always_comb begin
    pg = {st_nxt.latch[3], st_nxt.latch[7], st_nxt.latch[5]};
    if (st_nxt.latch[3]) begin
      case (st_nxt.latch[7:6])
        cbm_pkg::MODE_8K: begin
          b8 = {4'd0, pg, 1'b0};
          ba = {4'd0, pg, 1'b0};
          bc = {4'd0, pg, 1'b0};
          be = {4'd0, pg, 1'b0};
        end
        cbm_pkg::MODE_16K: begin
          b8 = {4'd0, pg, 1'b0};
          ba = {4'd0, pg, 1'b1};
          bc = {4'd0, pg, 1'b0};
          be = {4'd0, pg, 1'b1};
        end
        default: begin
          b8 = {4'd0, pg[2:1], 2'd0};
          ba = {4'd0, pg[2:1], 2'd1};
          bc = {4'd0, pg[2:1], 2'd2};
          be = {4'd0, pg[2:1], 2'd3};
        end
      endcase
    end else begin
      b8 = cbm_pkg::FIXED_BANK0;
      ba = cbm_pkg::FIXED_BANK1;
      bc = st_nxt.scr_bank;
      be = cbm_pkg::FIXED_BANK3;
    end
  end

  always_comb begin
    res_nxt.bank_6000 = cbm_pkg::BANK_6000;
    res_nxt.bank_8000 = b8;
    res_nxt.bank_a000 = ba;
    res_nxt.bank_c000 = bc;
    res_nxt.bank_e000 = be;
    res_nxt.chr_bank  = st_nxt.latch[2:1];
    res_nxt.mirroring = !st_nxt.latch[2];
    res_nxt.irq_line  = st_nxt.irq_line;
  end

  assign vld_nxt = accept ? 1'b1 : (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      vld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Result payload loads only with a new request; holds while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {{(cbm_pkg::OUT_TDATA_W - $bits(cbm_pkg::result_t)){1'b0}}, res_r};

endmodule

`default_nettype wire

[hdl/cbm_checker.sv]
// Port-level checker for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg for the output tdata width and the fixed $6000 bank.
`default_nettype none

module cbm_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [cbm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Held result must not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty result register");

  // Every taken request yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("request taken without a result");

  // $6000 bank is fixed and mirroring is the inverse of chr bank high bit
  a_fixed_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] == cbm_pkg::BANK_6000 && out_tdata[42] != out_tdata[41])
    else $error("fixed bank or mirroring mismatch");

endmodule

bind cartridge_bank_mapper_with_irq cbm_checker u_cbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
